/* sv/ees_pkg.sv */
// Package for the embedded expression scanner: character codes, lexical
// state and result-kind encodings, and the descriptor passed front to back.
// No dependencies.
package ees_pkg;

	// character codes
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// deepest paren nesting inside a capture
	localparam logic [7:0] MAX_NESTING = 8'd255;

	// descriptor queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		LX_NORMAL = 4'b0001,
		LX_LINE   = 4'b0010,
		LX_BLOCK  = 4'b0100,
		LX_STRING = 4'b1000
	} lex_t;

	typedef enum logic [1:0] {
		KIND_TEXT  = 2'd0,
		KIND_EXPR  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// one input's results: hash_cnt flushed '#' bytes, then an optional tail
	typedef struct packed {
		logic [1:0] hash_cnt;
		logic       has_tail;
		logic [7:0] tail_byte;
		kind_t      tail_kind;
		logic       tail_done;
	} desc_t;

endpackage

/* sv/ees_in_if.sv */
// Input channel of the scanner: valid/ready handshake with one source byte
// or an end-of-stream mark. No dependencies.
interface ees_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source(output valid, output in_byte, output end_of_input, input ready);
	modport sink(input valid, input in_byte, input end_of_input, output ready);
endinterface

/* sv/ees_out_if.sv */
// Result channel of the scanner: valid/ready handshake with one emitted
// byte and its flags. No dependencies.
interface ees_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       expr_done;
	logic       last;

	modport source(output valid, output out_byte, output kind, output expr_done,
		output last, input ready);
	modport sink(input valid, input out_byte, input kind, input expr_done,
		input last, output ready);
endinterface

/* sv/embedded_expression_scanner_top.sv */
// Top level of the embedded expression scanner: front end, descriptor
// queue and back end. Depends on ees_pkg, ees_in_if, ees_out_if, ees_front,
// ees_queue and ees_back.
//
//  channel  | role        | payload                              | per transaction
//  ---------+-------------+--------------------------------------+----------------
//  stream   | input sink  | in_byte[7:0], end_of_input           | one byte or end
//  result   | output src  | out_byte[7:0], kind[1:0], expr_done, | one result
//           |             | last                                 |
//
// A byte is taken every cycle while the four-entry descriptor queue has room;
// the lexers and marker matcher settle each byte in the cycle it is accepted.
// The back end drains one result per cycle while result.ready allows; each
// input causes 0 to 3 results, and the rare multi-result flushes are soaked
// up by the queue; descriptors are registered there, results in the output stage.
// Reset clears the lexer state, queue pointers and output valid; no clearing
// pass. A stall on result backs up through the queue to stream.ready alone.
module embedded_expression_scanner_top import ees_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ees_in_if.sink    stream,
	ees_out_if.source result
);

	// front to queue
	logic  push;
	desc_t push_desc;
	logic  queue_full;

	// queue to back
	logic  pop;
	logic  queue_empty;
	desc_t head;

	// front: lexing, marker match, nesting; at most one descriptor per transaction
	ees_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.queue_full (queue_full),
		.push       (push),
		.push_desc  (push_desc)
	);

	// decouples the one-byte-per-cycle front from the result-per-cycle back; either can stall
	ees_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (queue_full),
		.pop       (pop),
		.empty     (queue_empty),
		.head      (head)
	);

	// back: flushed '#' bytes first, then the tail byte, last on the final one
	ees_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (queue_empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

/* sv/ees_front.sv */
// Front end of the scanner: accepts bytes, runs the text and capture lexers
// and the marker matcher, and pushes at most one result descriptor per transaction.
// Depends on ees_pkg and ees_in_if.
module ees_front import ees_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ees_in_if.sink    stream,
	input  logic      queue_full,
	output logic      push,
	output desc_t     push_desc
);

	logic       capturing_q, capturing_d;
	lex_t       text_lex_q, text_lex_d;
	logic [7:0] text_prev_q, text_prev_d;
	logic [7:0] text_prev2_q, text_prev2_d;
	logic [1:0] marker_q, marker_d;
	lex_t       cap_lex_q, cap_lex_d;
	logic [7:0] cap_prev_q, cap_prev_d;
	logic [7:0] cap_prev2_q, cap_prev2_d;
	logic [7:0] nest_q, nest_d;

	logic       accept;
	desc_t      desc;

	assign stream.ready = !queue_full;
	assign accept       = stream.valid && !queue_full;
	assign push         = accept && (desc.hash_cnt != 2'd0 || desc.has_tail);
	assign push_desc    = desc;

	always_comb begin
		logic [7:0] c;
		lex_t       st;
		logic [7:0] pv;
		logic       match;
		logic [7:0] nd;

		c = stream.in_byte;
		st = text_lex_q;
		pv = text_prev_q;
		match = 1'b0;
		nd = nest_q;

		capturing_d  = capturing_q;
		text_lex_d   = text_lex_q;
		text_prev_d  = text_prev_q;
		text_prev2_d = text_prev2_q;
		marker_d     = marker_q;
		cap_lex_d    = cap_lex_q;
		cap_prev_d   = cap_prev_q;
		cap_prev2_d  = cap_prev2_q;
		nest_d       = nest_q;

		desc           = '0;
		desc.tail_kind = KIND_TEXT;

		if (stream.end_of_input) begin
			if (capturing_q) begin
				desc.has_tail  = 1'b1;
				desc.tail_byte = 8'h00;
				desc.tail_kind = KIND_ERROR;
			end else begin
				desc.hash_cnt = marker_q;
			end
			capturing_d  = 1'b0;
			text_lex_d   = LX_NORMAL;
			text_prev_d  = 8'h00;
			text_prev2_d = 8'h00;
			marker_d     = 2'd0;
			cap_lex_d    = LX_NORMAL;
			cap_prev_d   = 8'h00;
			cap_prev2_d  = 8'h00;
			nest_d       = 8'd0;
		end else if (capturing_q) begin
			st = cap_lex_q;
			pv = cap_prev_q;
			if (st == LX_NORMAL && c == CH_LPAREN && nest_q == MAX_NESTING) begin
				// nesting overflow: abandon capture, lexer left as it is
				desc.has_tail  = 1'b1;
				desc.tail_byte = c;
				desc.tail_kind = KIND_ERROR;
				capturing_d    = 1'b0;
				nest_d         = 8'd0;
			end else begin
				if (st == LX_NORMAL && c == CH_LPAREN)
					nd = nest_q + 8'd1;
				else if (st == LX_NORMAL && c == CH_RPAREN && nest_q != 8'd0)
					nd = nest_q - 8'd1;

				priority if (st == LX_NORMAL && cap_prev2_q != CH_HASH && pv != CH_BSLASH
						&& c == CH_QUOTE) begin
					st = LX_STRING;
				end else if (st == LX_STRING && c == CH_QUOTE) begin
					if (cap_prev2_q == CH_BSLASH && pv == CH_BSLASH)
						pv = 8'h00;
					else if (pv != CH_BSLASH)
						st = LX_NORMAL;
				end else if (st == LX_NORMAL && c == CH_SEMI) begin
					st = LX_LINE;
				end else if (st == LX_LINE && c == CH_NL) begin
					st = LX_NORMAL;
				end else begin
					st = st;
				end

				cap_prev2_d    = pv;
				cap_prev_d     = c;
				cap_lex_d      = st;
				nest_d         = nd;
				desc.has_tail  = 1'b1;
				desc.tail_byte = c;
				desc.tail_kind = KIND_EXPR;
				desc.tail_done = (nd == 8'd0);
				capturing_d    = (nd != 8'd0);
			end
		end else begin
			priority if (st == LX_NORMAL && pv != CH_APOS && c == CH_QUOTE) begin
				st = LX_STRING;
			end else if (st == LX_STRING && c == CH_QUOTE) begin
				if (text_prev2_q == CH_BSLASH && pv == CH_BSLASH)
					pv = 8'h00;
				else if (pv != CH_BSLASH)
					st = LX_NORMAL;
			end else if (st == LX_NORMAL && pv == CH_SLASH && c == CH_SLASH) begin
				st = LX_LINE;
			end else if (st == LX_LINE && c == CH_NL) begin
				st = LX_NORMAL;
			end else if (st == LX_NORMAL && pv == CH_SLASH && c == CH_STAR) begin
				st = LX_BLOCK;
			end else if (st == LX_BLOCK && pv == CH_STAR && c == CH_SLASH) begin
				st = LX_NORMAL;
			end else begin
				st = st;
			end

			text_prev2_d = pv;
			text_prev_d  = c;
			text_lex_d   = st;

			match = (st == LX_NORMAL) &&
				((marker_q != 2'd2 && c == CH_HASH) || (marker_q == 2'd2 && c == CH_LPAREN));

			if (match) begin
				if (marker_q == 2'd2) begin
					// marker complete: open the capture with '('
					marker_d       = 2'd0;
					capturing_d    = 1'b1;
					nest_d         = 8'd1;
					cap_lex_d      = LX_NORMAL;
					cap_prev_d     = CH_LPAREN;
					cap_prev2_d    = 8'h00;
					desc.has_tail  = 1'b1;
					desc.tail_byte = CH_LPAREN;
					desc.tail_kind = KIND_EXPR;
				end else begin
					marker_d = marker_q + 2'd1;
				end
			end else if (marker_q == 2'd2 && st == LX_NORMAL && c == CH_HASH) begin
				// third '#': release the oldest, keep two held
				desc.hash_cnt = 2'd1;
			end else begin
				desc.hash_cnt = marker_q;
				if (st == LX_NORMAL && c == CH_HASH) begin
					marker_d = 2'd1;
				end else begin
					marker_d       = 2'd0;
					desc.has_tail  = 1'b1;
					desc.tail_byte = c;
					desc.tail_kind = KIND_TEXT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q  <= 1'b0;
			text_lex_q   <= LX_NORMAL;
			text_prev_q  <= 8'h00;
			text_prev2_q <= 8'h00;
			marker_q     <= 2'd0;
			cap_lex_q    <= LX_NORMAL;
			cap_prev_q   <= 8'h00;
			cap_prev2_q  <= 8'h00;
			nest_q       <= 8'd0;
		end else if (accept) begin
			capturing_q  <= capturing_d;
			text_lex_q   <= text_lex_d;
			text_prev_q  <= text_prev_d;
			text_prev2_q <= text_prev2_d;
			marker_q     <= marker_d;
			cap_lex_q    <= cap_lex_d;
			cap_prev_q   <= cap_prev_d;
			cap_prev2_q  <= cap_prev2_d;
			nest_q       <= nest_d;
		end
	end

endmodule

/* sv/ees_queue.sv */
// Short descriptor queue between the front and back ends.
// Depends on ees_pkg.
module ees_queue import ees_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output desc_t head
);

	desc_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/ees_back.sv */
// Back end of the scanner: expands each descriptor into its result
// transactions, one per cycle unless result stalls, into a registered
// output stage. Depends on ees_pkg and ees_out_if.
module ees_back import ees_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  desc_t     head,
	output logic      pop,
	ees_out_if.source result
);

	logic [1:0] idx_q;
	logic [1:0] total;
	logic       load;
	logic       is_last;
	logic       valid_q;
	logic [7:0] byte_q;
	kind_t      kind_q;
	logic       done_q;
	logic       last_q;

	assign total   = head.hash_cnt + {1'b0, head.has_tail};
	assign is_last = (idx_q + 2'd1 == total);
	assign load    = !empty && (!valid_q || result.ready);
	assign pop     = load && is_last;

	assign result.valid     = valid_q;
	assign result.out_byte  = byte_q;
	assign result.kind      = kind_q;
	assign result.expr_done = done_q;
	assign result.last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (result.ready)
				valid_q <= 1'b0;
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= is_last;
			if (idx_q < head.hash_cnt) begin
				byte_q <= CH_HASH;
				kind_q <= KIND_TEXT;
				done_q <= 1'b0;
			end else begin
				byte_q <= head.tail_byte;
				kind_q <= head.tail_kind;
				done_q <= head.tail_done;
			end
		end
	end

endmodule

/* sv/ees_checker.sv */
// Port-level checks on the scanner's result channel, and the bind that
// attaches them to embedded_expression_scanner_top. Depends on ees_pkg.
module ees_checker import ees_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] out_byte,
	input logic [1:0] kind,
	input logic       expr_done,
	input logic       last
);

	// a stalled result transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(kind)
			&& $stable(expr_done) && $stable(last))
		else $error("result changed while stalled");

	// closing byte is an expression byte and ends its input's results
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && expr_done |-> kind == KIND_EXPR && last)
		else $error("expr_done on a non-final or non-expression result");

	// an error is always the only, hence final, result of its input
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_ERROR |-> last && !expr_done)
		else $error("error result not final");

	// no unused kind code
	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> kind == KIND_TEXT || kind == KIND_EXPR || kind == KIND_ERROR)
		else $error("undefined result kind");

endmodule

bind embedded_expression_scanner_top ees_checker u_ees_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (result.valid),
	.ready     (result.ready),
	.out_byte  (result.out_byte),
	.kind      (result.kind),
	.expr_done (result.expr_done),
	.last      (result.last)
);

/* bench/tb_top.sv */
// Self-checking bench for embedded_expression_scanner_top: directed cases, nesting limit,
// a long result stall, then random scanning. Needs ees_pkg, ees_in_if, ees_out_if and the RTL.
// Expected results come from a scan predictor kept in step with every accepted transaction.
module tb_top;
	import ees_pkg::*;

	// one expected or observed result transaction
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       done;
		logic       last;
	} scan_result_t;

	logic clk;
	logic arst_n;

	ees_in_if  stream_if();
	ees_out_if result_if();

	embedded_expression_scanner_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	// ------------------------------------------------------------------
	// Scan predictor state: text lexer, held marker hashes, capture lexer
	// and paren depth. Mirrors the block's state after reset.
	// ------------------------------------------------------------------
	logic       cap_mode     = 1'b0;
	lex_t       txt_lex      = LX_NORMAL;
	logic [7:0] txt_prev     = 8'h00;
	logic [7:0] txt_prev2    = 8'h00;
	int         held_hashes  = 0;
	lex_t       cap_lex      = LX_NORMAL;
	logic [7:0] cap_prev     = 8'h00;
	logic [7:0] cap_prev2    = 8'h00;
	int         nest         = 0;

	scan_result_t step_results[$];     // results of the transaction being predicted
	scan_result_t pending_results[$];  // expected results not yet seen on the output

	// bookkeeping
	int  failures      = 0;
	int  bytes_sent    = 0;
	int  results_seen  = 0;
	int  exprs_closed  = 0;
	int  errors_seen   = 0;

	// idling and hold-off controls shared with the driver processes
	bit  sender_idle   = 1'b0;
	bit  receiver_idle = 1'b0;
	bit  hold_req      = 1'b0;

	localparam int LONG_HOLD = 80;

	// ------------------------------------------------------------------
	// Clock and timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	task automatic emit(input logic [7:0] d, input kind_t k, input logic dn);
		scan_result_t r;
		r.data = d;
		r.kind = k;
		r.done = dn;
		r.last = 1'b0;
		step_results.push_back(r);
	endtask

	// text mode: C lexer, marker matching with held '#' bytes
	task automatic text_step(input logic [7:0] c);
		logic [7:0] pv;
		logic [7:0] pv2;
		logic [7:0] want;
		lex_t       st;
		int         m;
		pv2 = txt_prev2;
		pv  = txt_prev;
		st  = txt_lex;
		m   = held_hashes;
		if (st == LX_NORMAL && pv != CH_APOS && c == CH_QUOTE) begin
			st = LX_STRING;
		end else if (st == LX_STRING && c == CH_QUOTE) begin
			// a quote after a doubled backslash still counts as escaped and leaves the string open
			if (pv2 == CH_BSLASH && pv == CH_BSLASH) pv = 8'h00;
			else if (pv != CH_BSLASH) st = LX_NORMAL;
		end else if (st == LX_NORMAL && pv == CH_SLASH && c == CH_SLASH) begin
			st = LX_LINE;
		end else if (st == LX_LINE && c == CH_NL) begin
			st = LX_NORMAL;
		end else if (st == LX_NORMAL && pv == CH_SLASH && c == CH_STAR) begin
			st = LX_BLOCK;
		end else if (st == LX_BLOCK && pv == CH_STAR && c == CH_SLASH) begin
			st = LX_NORMAL;
		end
		txt_prev2 = pv;
		txt_prev  = c;
		txt_lex   = st;
		want = (m == 2) ? CH_LPAREN : CH_HASH;
		if (st == LX_NORMAL && c == want) begin
			m++;
			if (m == 3) begin
				// marker complete: hashes dropped, '(' opens the expression
				m         = 0;
				cap_mode  = 1'b1;
				nest      = 1;
				cap_lex   = LX_NORMAL;
				cap_prev  = CH_LPAREN;
				cap_prev2 = 8'h00;
				emit(CH_LPAREN, KIND_EXPR, 1'b0);
			end
		end else if (m == 2 && st == LX_NORMAL && c == CH_HASH) begin
			// third hash: oldest goes out, two stay held
			emit(CH_HASH, KIND_TEXT, 1'b0);
		end else begin
			repeat (m) emit(CH_HASH, KIND_TEXT, 1'b0);
			m = 0;
			if (st == LX_NORMAL && c == CH_HASH) m = 1;
			else emit(c, KIND_TEXT, 1'b0);
		end
		held_hashes = m;
	endtask

	// capture mode: paren depth, strings (#\" excepted), ; comments
	task automatic capture_step(input logic [7:0] c);
		logic [7:0] pv;
		logic [7:0] pv2;
		lex_t       st;
		pv2 = cap_prev2;
		pv  = cap_prev;
		st  = cap_lex;
		if (st == LX_NORMAL) begin
			if (c == CH_LPAREN) begin
				if (nest >= MAX_NESTING) begin
					emit(c, KIND_ERROR, 1'b0);
					cap_mode = 1'b0;
					nest     = 0;
					return;
				end
				nest++;
			end else if (c == CH_RPAREN) begin
				if (nest > 0) nest--;
			end
		end
		if (st == LX_NORMAL && pv2 != CH_HASH && pv != CH_BSLASH && c == CH_QUOTE) begin
			st = LX_STRING;
		end else if (st == LX_STRING && c == CH_QUOTE) begin
			if (pv2 == CH_BSLASH && pv == CH_BSLASH) pv = 8'h00;
			else if (pv != CH_BSLASH) st = LX_NORMAL;
		end else if (st == LX_NORMAL && c == CH_SEMI) begin
			st = LX_LINE;
		end else if (st == LX_LINE && c == CH_NL) begin
			st = LX_NORMAL;
		end
		cap_prev2 = pv;
		cap_prev  = c;
		cap_lex   = st;
		if (nest == 0) begin
			emit(c, KIND_EXPR, 1'b1);
			cap_mode = 1'b0;
		end else begin
			emit(c, KIND_EXPR, 1'b0);
		end
	endtask

	// works out the results of one accepted transaction and queues them
	task automatic predict_scan(input logic [7:0] c, input logic eoi);
		scan_result_t r;
		step_results.delete();
		if (eoi) begin
			if (cap_mode) emit(8'h00, KIND_ERROR, 1'b0);
			else repeat (held_hashes) emit(CH_HASH, KIND_TEXT, 1'b0);
			// end of stream puts everything back to its reset value
			cap_mode    = 1'b0;
			txt_lex     = LX_NORMAL;
			txt_prev    = 8'h00;
			txt_prev2   = 8'h00;
			held_hashes = 0;
			cap_lex     = LX_NORMAL;
			cap_prev    = 8'h00;
			cap_prev2   = 8'h00;
			nest        = 0;
		end else if (cap_mode) begin
			capture_step(c);
		end else begin
			text_step(c);
		end
		for (int i = 0; i < step_results.size(); i++) begin
			r      = step_results[i];
			r.last = (i == step_results.size() - 1);
			pending_results.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Stream driver: inputs change on the falling edge, acceptance is seen
	// at the rising edge, where the predictor is advanced.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		int gap;
		@(negedge clk);
		if (sender_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			stream_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stream_if.valid        <= 1'b1;
		stream_if.in_byte      <= b;
		stream_if.end_of_input <= eoi;
		do @(posedge clk); while (!stream_if.ready);
		predict_scan(b, eoi);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	// end of stream; the byte field is ignored so it carries noise
	task automatic send_end();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// a byte biased towards the characters the lexers care about
	function automatic logic [7:0] pick_token();
		case ($urandom_range(0, 15))
			0, 1:    return CH_HASH;
			2, 3:    return CH_LPAREN;
			4, 5:    return CH_RPAREN;
			6:       return CH_QUOTE;
			7:       return CH_BSLASH;
			8:       return CH_SLASH;
			9:       return CH_STAR;
			10:      return CH_SEMI;
			11:      return CH_NL;
			12:      return CH_APOS;
			13:      return 8'($urandom_range(8'h61, 8'h7A));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// finish any open expression, steered by the predicted capture lexer
	task automatic close_capture();
		for (int i = 0; i < 400 && cap_mode; i++) begin
			case (cap_lex)
				LX_STRING: send_byte((cap_prev == CH_BSLASH) ? 8'h61 : CH_QUOTE, 1'b0);
				LX_LINE:   send_byte(CH_NL, 1'b0);
				default:   send_byte(CH_RPAREN, 1'b0);
			endcase
		end
	endtask

	// leave any text string or comment so that a marker will be seen
	task automatic leave_text_comment();
		for (int i = 0; i < 8 && txt_lex != LX_NORMAL; i++) begin
			case (txt_lex)
				LX_STRING: send_byte((txt_prev == CH_BSLASH) ? 8'h61 : CH_QUOTE, 1'b0);
				LX_LINE:   send_byte(CH_NL, 1'b0);
				default:   send_byte((txt_prev == CH_STAR) ? CH_SLASH : CH_STAR, 1'b0);
			endcase
		end
	endtask

	// marker, random expression body, then a proper close
	task automatic send_expression(input int body_len);
		close_capture();
		leave_text_comment();
		send_text("##(");
		for (int i = 0; i < body_len && cap_mode; i++) send_byte(pick_token(), 1'b0);
		close_capture();
	endtask

	// one random chunk: well-formed expressions, token text, noise, a broken marker or an end
	task automatic send_random_chunk();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: send_expression($urandom_range(1, 12));
			4, 5, 6:    repeat ($urandom_range(1, 8)) send_byte(pick_token(), 1'b0);
			7:          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
			8: begin
				// broken marker
				send_text("##");
				send_byte(pick_token(), 1'b0);
			end
			default: begin
				if ($urandom_range(0, 1)) send_end();
				else send_byte(pick_token(), 1'b0);
			end
		endcase
	endtask

	task automatic wait_results_drained();
		// nothing more on offer: drop valid so the last byte is not taken again
		@(negedge clk);
		stream_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// byte extremes, comment and string handling, marker edge cases,
	// the #\" character inside an expression, and the three end-of-stream cases
	task automatic test_directed_cases();
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("/*##(*/");         // marker hidden in a block comment
		send_text("\"\\\\\"");        // doubled backslash then a quote that leaves the string open
		send_text("'\"");             // quote after apostrophe opens no string
		send_text("x##y");            // mismatch: two hashes flushed plus the byte
		send_text("###(");            // third hash goes out, marker still found
		send_text("#\\\"\"a\";)\n)"); // char literal, string, ; comment, close
		send_text("##");
		send_end();                   // held hashes flushed at end of stream
		send_text("##(");
		send_end();                   // end inside an expression: error
		send_end();                   // end with nothing held: no result
		wait_results_drained();
	endtask

	// deepest legal nesting closes normally; one more '(' overflows
	task automatic test_nesting_limit();
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		close_capture();
		leave_text_comment();
		send_text("##(");
		repeat (MAX_NESTING - 1) send_byte(CH_LPAREN, 1'b0);
		close_capture();
		send_text("##(");
		repeat (MAX_NESTING - 1) send_byte(CH_LPAREN, 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		wait_results_drained();
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	// transactions, so the queue fills and stream.ready drops
	task automatic test_result_backpressure();
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		hold_req      = 1'b1;
		repeat (3) send_text("a##b");
		send_expression(10);
		send_text("###x");
		wait_results_drained();
	endtask

	task automatic test_random_scan();
		int target;
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		target = bytes_sent + 250;
		while (bytes_sent < target) begin
			// now and then re-pick idling on each side; off gives runs at full rate
			if ($urandom_range(0, 7) == 0) begin
				sender_idle   = $urandom_range(0, 1);
				receiver_idle = $urandom_range(0, 1);
			end
			send_random_chunk();
		end
		wait_results_drained();
	endtask

	// last stretch at full rate on both sides, closed by end of stream
	task automatic test_quiet_tail();
		int target;
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		target = bytes_sent + 40;
		while (bytes_sent < target) send_random_chunk();
		send_end();
	endtask

	// ------------------------------------------------------------------
	// Result receiver: ready changes on the falling edge. A hold request
	// gives a long stall set by LONG_HOLD, otherwise random bursts when enabled.
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD - 1;
				result_if.ready <= 1'b0;
			end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: each transaction against the oldest expectation
	// ------------------------------------------------------------------
	initial begin
		scan_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready) begin
				results_seen++;
				if (result_if.expr_done) exprs_closed++;
				if (result_if.kind == KIND_ERROR) errors_seen++;
				if (pending_results.size() == 0) begin
					$error("result with none expected: out_byte %02h kind %0d",
						result_if.out_byte, result_if.kind);
					failures++;
				end else begin
					want = pending_results.pop_front();
					if (result_if.out_byte !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, result_if.out_byte);
						failures++;
					end
					if (result_if.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result_if.kind);
						failures++;
					end
					if (result_if.expr_done !== want.done) begin
						$error("expr_done: expected %0b, got %0b", want.done, result_if.expr_done);
						failures++;
					end
					if (result_if.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result_if.last);
						failures++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: one reset, then the tests in turn
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		stream_if.valid        = 1'b0;
		stream_if.in_byte      = 8'h00;
		stream_if.end_of_input = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_nesting_limit();
		test_result_backpressure();
		test_random_scan();
		test_quiet_tail();

		@(negedge clk);
		stream_if.valid <= 1'b0;
		wait_results_drained();
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			failures++;
		end

		$display("Scanned %0d input transactions and checked %0d results,",
			bytes_sent, results_seen);
		$display("with %0d expressions closed and %0d error results.",
			exprs_closed, errors_seen);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
